@@ rtl/core/u2u_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Byte classes, the queue item type and the overlong-form limits.
// ----------------------------------------------------------------------------
`default_nettype none

package u2u_pkg;

  localparam int unsigned U2U_FIFO_DEPTH = 2;
  localparam logic [15:0] U2U_MAX_UNITS_RST = 16'hFFFF;

  typedef enum logic [2:0] {
    CLS_ZERO    = 3'd0,
    CLS_ASCII   = 3'd1,
    CLS_CONT    = 3'd2,
    CLS_LEAD    = 3'd3,
    CLS_INVALID = 3'd4
  } byte_class_e;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    byte_class_e cls;
    logic [6:0]  bits;     // ASCII value, continuation payload or lead payload
    logic [2:0]  seq_len;  // sequence length for a lead byte
    logic        last;
  } item_t;

  // Smallest legal value for a sequence of the given length.
  function automatic logic [30:0] min_value(input logic [2:0] len);
    logic [30:0] v;
    case (len)
      3'd2:    v = 31'h0000080;
      3'd3:    v = 31'h0000800;
      3'd4:    v = 31'h0010000;
      3'd5:    v = 31'h0200000;
      default: v = 31'h4000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/u2u_in_if.sv @@
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel that carries one UTF-8 byte and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/u2u_out_if.sv @@
// ----------------------------------------------------------------------------
// Code unit channel
// Valid/ready channel that carries one decoded result.
// ----------------------------------------------------------------------------
`default_nettype none

interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic        unit_valid;
  logic [15:0] code_unit;
  logic        string_done;
  logic [15:0] units_written;
  logic        terminator_fits;

  modport source (output valid, output unit_valid, output code_unit, output string_done,
                  output units_written, output terminator_fits, input ready);
  modport sink   (input valid, input unit_valid, input code_unit, input string_done,
                  input units_written, input terminator_fits, output ready);
endinterface

`default_nettype wire

@@ rtl/core/u2u_front.sv @@
// ----------------------------------------------------------------------------
// Byte classifier
// Accept source bytes and sort them into ASCII, lead, continuation, zero
// or invalid before they enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_front (
  u2u_in_if.sink         in_i,
  output logic           push_valid_o,
  output u2u_pkg::item_t push_item_o,
  input  logic           push_ready_i
);
  import u2u_pkg::*;

  logic [7:0] b;

  assign b            = in_i.data_byte;
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

  always_comb begin
    push_item_o.last    = in_i.last_byte;
    push_item_o.bits    = b[6:0];
    push_item_o.seq_len = 3'd0;
    push_item_o.cls     = CLS_INVALID;
    if (b == 8'h00) begin
      push_item_o.cls = CLS_ZERO;
    end else if (!b[7]) begin
      push_item_o.cls = CLS_ASCII;
    end else if (b[7:6] == 2'b10) begin
      push_item_o.cls  = CLS_CONT;
      push_item_o.bits = {1'b0, b[5:0]};
    end else if (b[7:5] == 3'b110) begin
      push_item_o.cls     = CLS_LEAD;
      push_item_o.seq_len = 3'd2;
      push_item_o.bits    = {2'b0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      push_item_o.cls     = CLS_LEAD;
      push_item_o.seq_len = 3'd3;
      push_item_o.bits    = {3'b0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      push_item_o.cls     = CLS_LEAD;
      push_item_o.seq_len = 3'd4;
      push_item_o.bits    = {4'b0, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      push_item_o.cls     = CLS_LEAD;
      push_item_o.seq_len = 3'd5;
      push_item_o.bits    = {5'b0, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      push_item_o.cls     = CLS_LEAD;
      push_item_o.seq_len = 3'd6;
      push_item_o.bits    = {6'b0, b[0]};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/u2u_fifo.sv @@
// ----------------------------------------------------------------------------
// Classified byte queue
// Small FIFO that decouples the classifier from the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_fifo #(
  parameter int unsigned Depth = u2u_pkg::U2U_FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  u2u_pkg::item_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output u2u_pkg::item_t pop_item_o,
  input  logic           pop_ready_i
);
  import u2u_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  assign push_ready_o = (cnt_q != DepthC);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign wr_en        = push_valid_i && push_ready_o;
  assign rd_en        = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/u2u_back.sv @@
// ----------------------------------------------------------------------------
// Sequence decoder
// Assemble multi-byte sequences, count code units and register results.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    max_units_i,
  input  logic           pop_valid_i,
  input  u2u_pkg::item_t pop_item_i,
  output logic           pop_ready_o,
  u2u_out_if.source      out_o
);
  import u2u_pkg::*;

  logic [30:0] acc_q, acc_d;
  logic [2:0]  need_q, need_d;
  logic [2:0]  len_q, len_d;
  logic [15:0] count_q, count_d;
  logic        stopped_q, stopped_d;

  logic        out_valid_q;
  logic        unit_valid_q, done_q, fits_q;
  logic [15:0] code_q, written_q;

  logic        take, active, have, emit;
  logic [30:0] acc_shift;
  logic [15:0] unit, count_inc;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign take        = pop_valid_i && pop_ready_o;
  assign active      = !stopped_q && (count_q < max_units_i);
  assign acc_shift   = {acc_q[24:0], pop_item_i.bits[5:0]};
  assign count_inc   = count_q + 16'd1;

  always_comb begin
    acc_d     = acc_q;
    need_d    = need_q;
    len_d     = len_q;
    count_d   = count_q;
    stopped_d = stopped_q;
    have      = 1'b0;
    unit      = '0;
    if (active) begin
      if (need_q != 3'd0 && pop_item_i.cls == CLS_CONT) begin
        acc_d  = acc_shift;
        need_d = need_q - 3'd1;
        if (need_q == 3'd1) begin
          // Drop overlong forms.
          have   = (acc_shift >= min_value(len_q));
          unit   = acc_shift[15:0];
          acc_d  = '0;
          len_d  = '0;
        end
      end else begin
        // Any open sequence is abandoned; handle the byte fresh.
        acc_d  = '0;
        need_d = '0;
        len_d  = '0;
        case (pop_item_i.cls)
          CLS_ZERO:  stopped_d = 1'b1;
          CLS_ASCII: begin
            have = 1'b1;
            unit = {9'b0, pop_item_i.bits};
          end
          CLS_LEAD: begin
            len_d  = pop_item_i.seq_len;
            acc_d  = {24'b0, pop_item_i.bits};
            need_d = pop_item_i.seq_len - 3'd1;
          end
          default: ;
        endcase
      end
      if (have) begin
        count_d = count_inc;
        if (count_inc >= max_units_i) begin
          stopped_d = 1'b1;
        end
      end
    end
    if (pop_item_i.last) begin
      acc_d     = '0;
      need_d    = '0;
      len_d     = '0;
      count_d   = '0;
      stopped_d = 1'b0;
    end
  end

  assign emit = have || pop_item_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      need_q      <= '0;
      len_q       <= '0;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        acc_q     <= acc_d;
        need_q    <= need_d;
        len_q     <= len_d;
        count_q   <= count_d;
        stopped_q <= stopped_d;
      end
      if (take && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The count reported on the last byte is the post-update count.
  logic [15:0] final_count;
  assign final_count = have ? count_inc : count_q;

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      unit_valid_q <= have;
      code_q       <= have ? unit : 16'd0;
      done_q       <= pop_item_i.last;
      written_q    <= pop_item_i.last ? final_count : 16'd0;
      fits_q       <= pop_item_i.last && (final_count != 16'd0) &&
                      (final_count < max_units_i);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.unit_valid      = unit_valid_q;
  assign out_o.code_unit       = code_q;
  assign out_o.string_done     = done_q;
  assign out_o.units_written   = written_q;
  assign out_o.terminator_fits = fits_q;

endmodule

`default_nettype wire

@@ rtl/core/utf8_to_utf16_stream_decoder.sv @@
// Path: a byte transfer reaches its result through the queue, then the output register.
// Throughput: one source byte per cycle while out_o.ready accepts results; the per-byte
//   decode loop in the back end is combinational, so the output register is the only limit.
// Reset: asynchronous, active low; clears sequence state, unit count, queue and
//   output valid; max_units returns to 65535.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder
// Decode one UTF-8 byte per transfer into 16-bit code units, with a
// per-string summary on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_stream_decoder #(
  parameter int unsigned FifoDepth = u2u_pkg::U2U_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  u2u_in_if.sink      in_i,
  u2u_out_if.source   out_o
);
  import u2u_pkg::*;

  // Output buffer capacity; the user must write it only while the decoder is idle, as the block does not enforce this.
  logic [15:0] max_units_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= U2U_MAX_UNITS_RST;
    end else if (cfg_we_i) begin
      max_units_q <= cfg_wdata_i;
    end
  end

  // Front end: classify each byte as it is transferred in.
  logic  push_valid, push_ready;
  item_t push_item;

  u2u_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // Queue: hold classified bytes so each side can stall on its own.
  logic  pop_valid, pop_ready;
  item_t pop_item;

  u2u_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // Back end: advance the sequence state and register results; a byte that
  // produces no result is consumed without occupying the output register.
  u2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_units_i (max_units_q),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
